@@ rtl/u2u8_pkg.sv @@
// ----------------------------------------------------------------------------
// u2u8_pkg
// Shared types and constants for the UTF-16/UTF-32 to UTF-8 encoder.
// ----------------------------------------------------------------------------
package u2u8_pkg;

    // Result status codes
    localparam logic [2:0] ST_OK            = 3'd0;
    localparam logic [2:0] ST_UNPAIRED_HIGH = 3'd1;
    localparam logic [2:0] ST_BAD_PAIR      = 3'd2;
    localparam logic [2:0] ST_UNPAIRED_LOW  = 3'd3;
    localparam logic [2:0] ST_RANGE         = 3'd4;

    // Default depth of the job queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // Code unit classes (upper 22 bits of a surrogate)
    localparam logic [21:0] HIGH_SURR_TAG = 22'h36;  // 0xD800..0xDBFF
    localparam logic [21:0] LOW_SURR_TAG  = 22'h37;  // 0xDC00..0xDFFF
    localparam logic [31:0] MAX_SCALAR    = 32'h0010_FFFF;

    typedef struct packed {
        logic [31:0] code_unit;
        logic        string_end;
    } unit_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
        logic [2:0] status;
        logic       string_final;
    } byte_word_t;

    // One job: a code point to encode, or an error result
    typedef struct packed {
        logic [20:0] code_point;
        logic [1:0]  last_idx;   // number of bytes minus one
        logic [2:0]  status;
        logic        fin;
    } job_t;

endpackage

@@ rtl/utf16_to_utf8_encoder.sv @@
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder
// Transcodes wide code units into UTF-8 bytes with surrogate pairing and
// per-string error handling.
// ----------------------------------------------------------------------------
//  channel  handshake                 word
//  unit     unit_valid / unit_ready   u2u8_pkg::unit_word_t
//  byte     byte_valid / byte_ready   u2u8_pkg::byte_word_t
//
//  The front takes one unit per cycle while the job queue has room.
//  The back sends one byte per cycle while byte_ready is high, so a unit
//  yields 1 to 4 byte words; a held high surrogate or a dropped unit
//  takes no back time. First byte passes the job queue and the output
//  register after its unit is accepted. Reset (rst_n low) clears
//  surrogate and drop state, the queue and the output register. A stalled
//  byte channel fills the queue, then drops unit_ready.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder #(
    parameter int QUEUE_DEPTH = u2u8_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 unit_valid,
    output logic                 unit_ready,
    input  u2u8_pkg::unit_word_t unit_word,
    output logic                 byte_valid,
    input  logic                 byte_ready,
    output u2u8_pkg::byte_word_t byte_word
);

    logic           push;
    u2u8_pkg::job_t push_job;
    logic           queue_full;
    logic           head_valid;
    u2u8_pkg::job_t head_job;
    logic           pop;

    u2u8_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .unit_valid (unit_valid),
        .unit_ready (unit_ready),
        .unit_word  (unit_word),
        .queue_full (queue_full),
        .push       (push),
        .push_job   (push_job)
    );

    u2u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop)
    );

    u2u8_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_word  (byte_word)
    );

endmodule

@@ rtl/u2u8_front.sv @@
// ----------------------------------------------------------------------------
// u2u8_front
// Accepts code units, tracks surrogate and drop state, and queues one job
// per unit that yields results.
// ----------------------------------------------------------------------------
module u2u8_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 unit_valid,
    output logic                 unit_ready,
    input  u2u8_pkg::unit_word_t unit_word,
    input  logic                 queue_full,
    output logic                 push,
    output u2u8_pkg::job_t       push_job
);

    logic        high_pending_reg, high_pending_next;
    logic [9:0]  held_high_reg, held_high_next;
    logic        dropping_reg, dropping_next;

    logic        accept;
    logic        is_high;
    logic        is_low;
    logic        job_gen;
    logic [20:0] pair_point;
    logic [20:0] cp;

    assign unit_ready = !queue_full;
    assign accept     = unit_valid && unit_ready;

    // Classify the unit
    assign is_high = (unit_word.code_unit[31:10] == u2u8_pkg::HIGH_SURR_TAG);
    assign is_low  = (unit_word.code_unit[31:10] == u2u8_pkg::LOW_SURR_TAG);

    // Combine held high half with low half: 0x10000 + (h << 10) + l
    assign pair_point = {({1'b0, held_high_reg} + 11'd64), unit_word.code_unit[9:0]};

    // Decide job and next state
    always_comb
    begin
        high_pending_next = high_pending_reg;
        held_high_next    = held_high_reg;
        dropping_next     = dropping_reg;
        job_gen           = 1'b0;
        cp                = unit_word.code_unit[20:0];
        push_job.status   = u2u8_pkg::ST_OK;
        push_job.fin      = unit_word.string_end;

        if (dropping_reg)
        begin
            job_gen = 1'b0;
        end
        else if (high_pending_reg)
        begin
            job_gen = 1'b1;
            high_pending_next = 1'b0;
            held_high_next    = 10'd0;
            if (is_low)
            begin
                cp = pair_point;
            end
            else
            begin
                push_job.status = u2u8_pkg::ST_BAD_PAIR;
                dropping_next   = 1'b1;
            end
        end
        else if (is_high)
        begin
            if (unit_word.string_end)
            begin
                job_gen         = 1'b1;
                push_job.status = u2u8_pkg::ST_UNPAIRED_HIGH;
                dropping_next   = 1'b1;
            end
            else
            begin
                high_pending_next = 1'b1;
                held_high_next    = unit_word.code_unit[9:0];
            end
        end
        else if (is_low)
        begin
            job_gen         = 1'b1;
            push_job.status = u2u8_pkg::ST_UNPAIRED_LOW;
            dropping_next   = 1'b1;
        end
        else if (unit_word.code_unit > u2u8_pkg::MAX_SCALAR)
        begin
            job_gen         = 1'b1;
            push_job.status = u2u8_pkg::ST_RANGE;
            dropping_next   = 1'b1;
        end
        else
        begin
            job_gen = 1'b1;
        end

        // End of string clears everything
        if (unit_word.string_end)
        begin
            high_pending_next = 1'b0;
            held_high_next    = 10'd0;
            dropping_next     = 1'b0;
        end

        push_job.code_point = cp;
        if (push_job.status != u2u8_pkg::ST_OK || cp <= 21'h7F)
            push_job.last_idx = 2'd0;
        else if (cp <= 21'h7FF)
            push_job.last_idx = 2'd1;
        else if (cp <= 21'hFFFF)
            push_job.last_idx = 2'd2;
        else
            push_job.last_idx = 2'd3;
    end

    assign push = accept && job_gen;

    // Hold surrogate and drop state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_pending_reg <= 1'b0;
            held_high_reg    <= 10'd0;
            dropping_reg     <= 1'b0;
        end
        else if (accept)
        begin
            high_pending_reg <= high_pending_next;
            held_high_reg    <= held_high_next;
            dropping_reg     <= dropping_next;
        end
    end

endmodule

@@ rtl/u2u8_queue.sv @@
// ----------------------------------------------------------------------------
// u2u8_queue
// Small job queue between the front and the back.
// ----------------------------------------------------------------------------
module u2u8_queue #(
    parameter int DEPTH = u2u8_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  u2u8_pkg::job_t push_job,
    output logic           full,
    output logic           head_valid,
    output u2u8_pkg::job_t head_job,
    input  logic           pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    u2u8_pkg::job_t slots_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;

    assign full       = (count_reg == CW'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = slots_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        if (push && !pop)
            count_next = count_reg + CW'(1);
        else if (pop && !push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store jobs
    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_job;
    end

endmodule

@@ rtl/u2u8_back.sv @@
// ----------------------------------------------------------------------------
// u2u8_back
// Expands each queued job into its UTF-8 bytes, or into one error word,
// one word per cycle while byte_ready allows, through an output register.
// ----------------------------------------------------------------------------
module u2u8_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 head_valid,
    input  u2u8_pkg::job_t       head_job,
    output logic                 pop,
    output logic                 byte_valid,
    input  logic                 byte_ready,
    output u2u8_pkg::byte_word_t byte_word
);

    logic                 out_valid_reg;
    u2u8_pkg::byte_word_t out_word_reg, out_word_next;
    logic [1:0]           idx_reg, idx_next;
    logic                 load;
    logic [7:0]           enc [4];
    logic [20:0]          cp;

    assign cp   = head_job.code_point;
    assign load = head_valid && (!out_valid_reg || byte_ready);
    assign pop  = load && (idx_reg == head_job.last_idx);

    // Build bytes in order for the job's length
    always_comb
    begin
        enc[0] = 8'h00;
        enc[1] = 8'h00;
        enc[2] = 8'h00;
        enc[3] = 8'h00;
        case (head_job.last_idx)
            2'd0:
            begin
                enc[0] = {1'b0, cp[6:0]};
            end
            2'd1:
            begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            2'd2:
            begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            default:
            begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
            end
        endcase
    end

    // Select the current byte
    always_comb
    begin
        out_word_next.out_byte     = (head_job.status == u2u8_pkg::ST_OK) ? enc[idx_reg] : 8'h00;
        out_word_next.last_byte    = (idx_reg == head_job.last_idx);
        out_word_next.status       = head_job.status;
        out_word_next.string_final = head_job.fin;
        idx_next = pop ? 2'd0 : (load ? idx_reg + 2'd1 : idx_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            idx_reg <= idx_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (byte_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Hold output payload
    always_ff @(posedge clk)
    begin
        if (load)
            out_word_reg <= out_word_next;
    end

    assign byte_valid = out_valid_reg;
    assign byte_word  = out_word_reg;

endmodule

@@ dv/tb_utf16_to_utf8_encoder.sv @@
// ----------------------------------------------------------------------------
// tb_utf16_to_utf8_encoder
// Checks the wide-unit to UTF-8 encoder against a behavioral predictor.
// Directed tests cover every byte length at its boundaries, surrogate pairs
// and each error status. Random strings of well-formed units, pairs and noise
// follow, with bursts of idle on both channels. A final stretch runs with no
// idle at all. Each byte word is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_utf16_to_utf8_encoder;

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          DRAIN_CYCLES = 20;
    localparam logic [31:0] HIGH_FIRST   = 32'h0000_D800;
    localparam logic [31:0] HIGH_LAST    = 32'h0000_DBFF;
    localparam logic [31:0] LOW_FIRST    = 32'h0000_DC00;
    localparam logic [31:0] LOW_LAST     = 32'h0000_DFFF;
    localparam logic [31:0] SCALAR_TOP   = 32'h0010_FFFF;

    logic                 clk;
    logic                 rst_n;
    logic                 unit_valid;
    logic                 unit_ready;
    u2u8_pkg::unit_word_t unit_word;
    logic                 byte_valid;
    logic                 byte_ready;
    u2u8_pkg::byte_word_t byte_word;

    // Predictor state
    logic                 surr_held   = 1'b0;
    logic [9:0]           surr_bits   = '0;
    logic                 skip_to_end = 1'b0;
    u2u8_pkg::byte_word_t expected_bytes[$];

    bit idle_enable;
    int mismatch_count = 0;
    int cycle_count    = 0;

    utf16_to_utf8_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .unit_valid(unit_valid),
        .unit_ready(unit_ready),
        .unit_word (unit_word),
        .byte_valid(byte_valid),
        .byte_ready(byte_ready),
        .byte_word (byte_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Queue the UTF-8 bytes of one scalar value
    function automatic void queue_utf8_bytes(logic [20:0] cp, logic fin);
        logic [7:0]           b[4];
        int                   n;
        u2u8_pkg::byte_word_t item;
        if (cp <= 21'h7F)
        begin
            b[0] = cp[7:0];
            n = 1;
        end
        else if (cp <= 21'h7FF)
        begin
            b[0] = 8'hC0 | {3'b0, cp[10:6]};
            b[1] = 8'h80 | {2'b0, cp[5:0]};
            n = 2;
        end
        else if (cp <= 21'hFFFF)
        begin
            b[0] = 8'hE0 | {4'b0, cp[15:12]};
            b[1] = 8'h80 | {2'b0, cp[11:6]};
            b[2] = 8'h80 | {2'b0, cp[5:0]};
            n = 3;
        end
        else
        begin
            b[0] = 8'hF0 | {5'b0, cp[20:18]};
            b[1] = 8'h80 | {2'b0, cp[17:12]};
            b[2] = 8'h80 | {2'b0, cp[11:6]};
            b[3] = 8'h80 | {2'b0, cp[5:0]};
            n = 4;
        end
        for (int k = 0; k < n; k++)
        begin
            item = '{out_byte: b[k], last_byte: (k == n - 1),
                     status: u2u8_pkg::ST_OK, string_final: fin};
            expected_bytes.insert(expected_bytes.size(), item);
        end
    endfunction

    // Queue one error word and drop the rest of the string
    function automatic void queue_error_byte(logic [2:0] code, logic fin);
        u2u8_pkg::byte_word_t item;
        item = '{out_byte: 8'h00, last_byte: 1'b1,
                 status: code, string_final: fin};
        expected_bytes.insert(expected_bytes.size(), item);
        surr_held   = 1'b0;
        surr_bits   = '0;
        skip_to_end = 1'b1;
    endfunction

    // Work out the bytes that one accepted unit causes
    function automatic void predict_bytes(u2u8_pkg::unit_word_t w);
        logic [31:0] cu;
        logic        fin;
        logic        is_high;
        logic        is_low;
        cu      = w.code_unit;
        fin     = w.string_end;
        is_high = (cu >= HIGH_FIRST) && (cu <= HIGH_LAST);
        is_low  = (cu >= LOW_FIRST) && (cu <= LOW_LAST);
        if (skip_to_end)
        begin
        end
        else if (surr_held)
        begin
            if (is_low)
            begin
                surr_held = 1'b0;
                queue_utf8_bytes(21'h10000 + {1'b0, surr_bits, cu[9:0]}, fin);
                surr_bits = '0;
            end
            else
                queue_error_byte(u2u8_pkg::ST_BAD_PAIR, fin);
        end
        else if (is_high)
        begin
            if (fin)
                queue_error_byte(u2u8_pkg::ST_UNPAIRED_HIGH, fin);
            else
            begin
                surr_held = 1'b1;
                surr_bits = cu[9:0];
            end
        end
        else if (is_low)
            queue_error_byte(u2u8_pkg::ST_UNPAIRED_LOW, fin);
        else if (cu > SCALAR_TOP)
            queue_error_byte(u2u8_pkg::ST_RANGE, fin);
        else
            queue_utf8_bytes(cu[20:0], fin);
        // End of string clears all pairing and drop state
        if (fin)
        begin
            surr_held   = 1'b0;
            surr_bits   = '0;
            skip_to_end = 1'b0;
        end
    endfunction

    function automatic void report_field(string name, int exp_val, int act_val);
        if (exp_val != act_val)
        begin
            $display("%0t: mismatch on %s: expected 0x%0h, actual 0x%0h",
                     $time, name, exp_val, act_val);
            mismatch_count++;
        end
    endfunction

    // Predict on each accepted unit, then check each accepted byte word
    always @(posedge clk)
    begin
        u2u8_pkg::byte_word_t want;
        if (rst_n)
        begin
            if (unit_valid && unit_ready)
                predict_bytes(unit_word);
            if (byte_valid && byte_ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    $display("%0t: unexpected byte word: expected none, actual %h",
                             $time, byte_word);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    report_field("out_byte", want.out_byte, byte_word.out_byte);
                    report_field("last_byte", want.last_byte, byte_word.last_byte);
                    report_field("status", want.status, byte_word.status);
                    report_field("string_final", want.string_final,
                                 byte_word.string_final);
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Toggle byte_ready in random bursts
    initial
    begin
        byte_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (idle_enable && $urandom_range(0, 2) == 0)
                byte_ready <= 1'b0;
            else
                byte_ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
    end

    // Send one word; enter and leave on a falling edge
    task automatic send_unit(input logic [31:0] cu, input logic fin);
        int gap;
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 16);
            unit_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        unit_word  <= '{code_unit: cu, string_end: fin};
        unit_valid <= 1'b1;
        do
            @(posedge clk);
        while (!unit_ready);
        @(negedge clk);
    endtask

    task automatic test_utf8_lengths();
        send_unit(32'h0000_0000, 1'b0);
        send_unit(32'h0000_007F, 1'b0);
        send_unit(32'h0000_0080, 1'b0);
        send_unit(32'h0000_07FF, 1'b0);
        send_unit(32'h0000_0800, 1'b0);
        send_unit(32'h0000_D7FF, 1'b0);
        send_unit(32'h0000_E000, 1'b0);
        send_unit(32'h0000_FFFF, 1'b1);
    endtask

    task automatic test_surrogate_pairs();
        send_unit(HIGH_FIRST, 1'b0);
        send_unit(LOW_FIRST, 1'b0);
        send_unit(HIGH_LAST, 1'b0);
        send_unit(LOW_LAST, 1'b1);
        // Highest scalar given directly
        send_unit(SCALAR_TOP, 1'b1);
    endtask

    task automatic test_error_cases();
        // High surrogate as the last unit
        send_unit(HIGH_FIRST, 1'b1);
        // High then high, then drop until the string ends
        send_unit(HIGH_FIRST, 1'b0);
        send_unit(HIGH_LAST, 1'b0);
        send_unit(32'h0000_0041, 1'b0);
        send_unit(32'h0000_0042, 1'b1);
        // Lone low surrogate
        send_unit(LOW_LAST, 1'b1);
        // Out of range, then drop the end of the string
        send_unit(32'h0011_0000, 1'b0);
        send_unit(32'h0000_0041, 1'b1);
        send_unit(32'hFFFF_FFFF, 1'b1);
        // Out-of-range value while a high is held counts as a bad pair
        send_unit(HIGH_LAST, 1'b0);
        send_unit(32'hFFFF_FFFF, 1'b1);
    endtask

    // Send strings of mostly well-formed units with some noise
    task automatic test_random_strings(input int unit_total);
        int          sent;
        int          len;
        int          pick;
        logic        fin;
        logic [31:0] cu;
        sent = 0;
        while (sent < unit_total)
        begin
            len = $urandom_range(1, 8);
            for (int i = 0; i < len; i++)
            begin
                fin  = (i == len - 1);
                pick = $urandom_range(0, 99);
                if (pick < 20)
                    cu = $urandom_range(0, 32'h7F);
                else if (pick < 35)
                    cu = $urandom_range(32'h80, 32'h7FF);
                else if (pick < 50)
                    cu = ($urandom_range(0, 1) == 1) ? $urandom_range(32'h800, 32'hD7FF)
                                                     : $urandom_range(32'hE000, 32'hFFFF);
                else if (pick < 72)
                begin
                    // Well-formed pair
                    send_unit($urandom_range(HIGH_FIRST, HIGH_LAST), 1'b0);
                    sent++;
                    cu = $urandom_range(LOW_FIRST, LOW_LAST);
                end
                else if (pick < 77)
                    cu = $urandom_range(LOW_FIRST, LOW_LAST);
                else if (pick < 83)
                    cu = $urandom_range(HIGH_FIRST, HIGH_LAST);
                else if (pick < 88)
                    cu = $urandom_range(32'h11_0000, 32'hFFFF_FFFF);
                else if (pick < 92)
                    cu = $urandom_range(32'h1_0000, SCALAR_TOP);
                else
                    cu = $urandom;
                send_unit(cu, fin);
                sent++;
            end
        end
    endtask

    task automatic test_steady_stream(input int unit_total);
        idle_enable = 1'b0;
        test_random_strings(unit_total);
    endtask

    initial
    begin
        rst_n       = 1'b0;
        unit_valid  = 1'b0;
        unit_word   = '0;
        idle_enable = 1'b1;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_utf8_lengths();
        test_surrogate_pairs();
        test_error_cases();
        test_random_strings(320);
        test_steady_stream(60);
        unit_valid <= 1'b0;

        // Wait for the last bytes, then watch for strays
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ files.f @@
rtl/u2u8_pkg.sv
rtl/u2u8_front.sv
rtl/u2u8_queue.sv
rtl/u2u8_back.sv
rtl/utf16_to_utf8_encoder.sv
dv/tb_utf16_to_utf8_encoder.sv
